// File: design/mts_pkg.sv
// Package for the midpoint triangle subdivider.
// Holds command and result codes, the default sizes and the edge hash.
// No dependencies.
package mts_pkg;

   localparam int VERTEX_DEPTH_DEF = 4096;
   localparam int EDGE_DEPTH_DEF   = 8192;
   localparam int COORD_WIDTH_DEF  = 32;

   localparam int IDX_W   = 12;
   localparam int LIMIT_W = 13;
   localparam int KEY_W   = 24;
   localparam int KIND_W  = 2;
   localparam int CMD_W   = 2;
   localparam int FIELD_W = 32;

   localparam logic [CMD_W-1:0] CMD_RESET = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PASS  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TRI   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRI  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

   localparam logic [31:0] HASH_MUL = 32'd2654435761;

   // Result of one edge lookup handed from the edge table to the sequencer.
   typedef struct packed {
      logic                done;
      logic                found;
      logic                fail;
      logic [IDX_W-1:0]    value;
   } edge_rsp_type;

endpackage

// File: design/midpoint_triangle_subdivider.sv
// Top level of the midpoint triangle subdivider: sequencer and vertex store.
// Uses mts_pkg and mts_edge_table.
//
//  channel  ports                      handshake
//  request  req_*                      start high, busy low
//  result   rsp_*                      rsp_valid for one cycle
//  config   csr_we, csr_data           csr_we high
//
// A load, a reset mesh or start pass, and a triangle each run to the end before the next
// item is accepted; a triangle takes longer when its edges are new than when all three exist,
// and longer with each extra probe of the edge table, which makes one probe a cycle.
// After reset every entry of the edge table memory is swept once, with busy high;
// the sweep repeats after every 255 clears. The receiver cannot stall.
module midpoint_triangle_subdivider
   import mts_pkg::*;
#(
   parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
   parameter int EDGE_DEPTH   = EDGE_DEPTH_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [FIELD_W-1:0]  req_in_x,
   input  logic signed [FIELD_W-1:0]  req_in_y,
   input  logic signed [FIELD_W-1:0]  req_in_z,
   input  logic [IDX_W-1:0]           req_corner_a,
   input  logic [IDX_W-1:0]           req_corner_b,
   input  logic [IDX_W-1:0]           req_corner_c,
   input  logic                       csr_we,
   input  logic [LIMIT_W-1:0]         csr_data,
   output logic                       rsp_valid,
   output logic [KIND_W-1:0]          rsp_kind,
   output logic [IDX_W-1:0]           rsp_out_index,
   output logic signed [FIELD_W-1:0]  rsp_out_x,
   output logic signed [FIELD_W-1:0]  rsp_out_y,
   output logic signed [FIELD_W-1:0]  rsp_out_z,
   output logic [IDX_W-1:0]           rsp_out_a,
   output logic [IDX_W-1:0]           rsp_out_b,
   output logic [IDX_W-1:0]           rsp_out_c,
   output logic                       rsp_last
);

   localparam int VW = $clog2(VERTEX_DEPTH);
   localparam int CNT_W = VW + 1;
   localparam int CWD = COORD_WIDTH;

   localparam logic [3:0] S_IDLE = 4'd0, S_DO = 4'd1, S_RDP = 4'd2, S_RDQ = 4'd3,
                          S_LOOK = 4'd4, S_WAIT = 4'd5, S_MID = 4'd6, S_CH = 4'd7,
                          S_CLR = 4'd8, S_EMIT = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMD_W-1:0] cmd_ff;
   logic [FIELD_W-1:0] ix_ff, iy_ff, iz_ff;
   logic [IDX_W-1:0] a_ff, b_ff, c_ff;
   logic [1:0] edge_ff, edge_in;
   logic [1:0] child_ff, child_in;
   logic [IDX_W-1:0] m0_ff, m1_ff, m2_ff;
   logic [3*CWD-1:0] pv_ff;
   logic [3*CWD-1:0] vmem [VERTEX_DEPTH];
   logic [3*CWD-1:0] vrd_ff;
   logic [IDX_W-1:0] vraddr;
   logic             vwe;
   logic [3*CWD-1:0] vwdata;
   logic             rd_ok_ff;
   logic [3*CWD-1:0] rd_val;
   logic [IDX_W-1:0] ep, eq, lo, hi;
   logic             lim_hit;
   logic             et_clear, et_look, et_ins;
   edge_rsp_type     et_rsp;
   logic             table_sweep;
   logic             o_valid;
   logic [KIND_W-1:0] o_kind;
   logic [IDX_W-1:0] o_idx, o_a, o_b, o_c;
   logic [3*CWD-1:0] o_xyz;
   logic             o_last;
   logic [3*CWD-1:0] mid_v;

   // Effective limit compare.
   always_comb begin
      if ({{(32-LIMIT_W){1'b0}}, limit_ff} < VERTEX_DEPTH)
         lim_hit = {{(32-CNT_W){1'b0}}, count_ff} >= {{(32-LIMIT_W){1'b0}}, limit_ff};
      else
         lim_hit = {{(32-CNT_W){1'b0}}, count_ff} >= VERTEX_DEPTH;
   end

   // Ends of the current edge: (c,a), (a,b), (b,c).
   always_comb begin
      case (edge_ff)
         2'd0: begin ep = c_ff; eq = a_ff; end
         2'd1: begin ep = a_ff; eq = b_ff; end
         default: begin ep = b_ff; eq = c_ff; end
      endcase
      lo = (ep < eq) ? ep : eq;
      hi = (ep < eq) ? eq : ep;
   end

   // Vertex store memory.
   always_ff @(posedge clock) begin
      if (vwe) vmem[VW'(count_ff)] <= vwdata;
      vrd_ff <= vmem[VW'(vraddr)];
      rd_ok_ff <= {{(32-IDX_W){1'b0}}, vraddr} < {{(32-CNT_W){1'b0}}, count_ff}
                  && {{(32-IDX_W){1'b0}}, vraddr} < VERTEX_DEPTH;
   end
   assign rd_val = rd_ok_ff ? vrd_ff : '0;

   // Floor midpoint per coordinate.
   always_comb begin
      for (int d = 0; d < 3; d++) begin
         mid_v[d*CWD +: CWD] = CWD'(({pv_ff[d*CWD+CWD-1], pv_ff[d*CWD +: CWD]}
                             + {rd_val[d*CWD+CWD-1], rd_val[d*CWD +: CWD]}) >> 1);
      end
   end

   mts_edge_table #(.EDGE_DEPTH(EDGE_DEPTH)) u_edges (
      .clock(clock), .reset(reset), .clear(et_clear), .lookup(et_look),
      .key({lo, hi}), .insert(et_ins), .insert_value(IDX_W'(count_ff)),
      .rsp(et_rsp), .sweeping(table_sweep)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff; count_in = count_ff; edge_in = edge_ff; child_in = child_ff;
      vraddr = ep; vwe = 1'b0; vwdata = mid_v;
      et_clear = 1'b0; et_look = 1'b0; et_ins = 1'b0;
      o_valid = 1'b0; o_kind = KIND_ACK; o_idx = '0; o_xyz = '0;
      o_a = '0; o_b = '0; o_c = '0; o_last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) state_in = S_DO;
         end
         S_DO: begin
            case (cmd_ff)
               CMD_RESET, CMD_PASS: begin
                  et_clear = 1'b1; o_valid = 1'b1; o_last = 1'b1;
                  if (cmd_ff == CMD_RESET) count_in = '0;
                  state_in = S_CLR;
               end
               CMD_LOAD: begin
                  o_valid = 1'b1; o_last = 1'b1; state_in = S_IDLE;
                  if (lim_hit) o_kind = KIND_ERR;
                  else begin
                     vwe = 1'b1;
                     vwdata = {CWD'(iz_ff), CWD'(iy_ff), CWD'(ix_ff)};
                     o_kind = KIND_VERT; o_idx = IDX_W'(count_ff);
                     o_xyz = vwdata; count_in = count_ff + 1'b1;
                  end
               end
               default: begin
                  edge_in = 2'd0; state_in = S_LOOK;
               end
            endcase
         end
         S_CLR: state_in = S_IDLE;
         S_LOOK: begin
            et_look = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: begin
            if (et_rsp.done) begin
               if (et_rsp.found) begin
                  if (edge_ff == 2'd2) begin child_in = 2'd0; state_in = S_CH; end
                  else begin edge_in = edge_ff + 1'b1; state_in = S_LOOK; end
               end else if (et_rsp.fail || lim_hit) begin
                  o_valid = 1'b1; o_kind = KIND_ERR; o_last = 1'b1; state_in = S_IDLE;
               end else begin
                  vraddr = ep; state_in = S_RDP;
               end
            end
         end
         S_RDP: begin
            vraddr = eq; state_in = S_RDQ;
         end
         S_RDQ: state_in = S_MID;
         S_MID: begin
            vwe = 1'b1; et_ins = 1'b1;
            o_valid = 1'b1; o_kind = KIND_VERT; o_idx = IDX_W'(count_ff);
            o_xyz = mid_v; count_in = count_ff + 1'b1;
            if (edge_ff == 2'd2) begin child_in = 2'd0; state_in = S_CH; end
            else begin edge_in = edge_ff + 1'b1; state_in = S_LOOK; end
         end
         S_CH: begin
            o_valid = 1'b1; o_kind = KIND_TRI;
            case (child_ff)
               2'd0: begin o_a = a_ff; o_b = m1_ff; o_c = m0_ff; end
               2'd1: begin o_a = m1_ff; o_b = b_ff; o_c = m2_ff; end
               2'd2: begin o_a = m2_ff; o_b = c_ff; o_c = m0_ff; end
               default: begin o_a = m1_ff; o_b = m2_ff; o_c = m0_ff; o_last = 1'b1; end
            endcase
            child_in = child_ff + 1'b1;
            if (child_ff == 2'd3) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE) || table_sweep;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; limit_ff <= LIMIT_W'(4096);
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rsp_valid <= o_valid;
         if (csr_we) limit_ff <= csr_data;
      end
      edge_ff <= edge_in; child_ff <= child_in;
      if (state_ff == S_RDQ) pv_ff <= rd_val;
      if (state_ff == S_WAIT && et_rsp.done && et_rsp.found) begin
         case (edge_ff)
            2'd0: m0_ff <= et_rsp.value;
            2'd1: m1_ff <= et_rsp.value;
            default: m2_ff <= et_rsp.value;
         endcase
      end
      if (state_ff == S_MID) begin
         case (edge_ff)
            2'd0: m0_ff <= IDX_W'(count_ff);
            2'd1: m1_ff <= IDX_W'(count_ff);
            default: m2_ff <= IDX_W'(count_ff);
         endcase
      end
      if (start && !busy) begin
         cmd_ff <= req_cmd; ix_ff <= req_in_x; iy_ff <= req_in_y; iz_ff <= req_in_z;
         a_ff <= req_corner_a; b_ff <= req_corner_b; c_ff <= req_corner_c;
      end
      rsp_kind <= o_kind; rsp_out_index <= o_idx; rsp_last <= o_last;
      rsp_out_x <= FIELD_W'(o_xyz[0 +: CWD]);
      rsp_out_y <= FIELD_W'(o_xyz[CWD +: CWD]);
      rsp_out_z <= FIELD_W'(o_xyz[2*CWD +: CWD]);
      rsp_out_a <= o_a; rsp_out_b <= o_b; rsp_out_c <= o_c;
   end

   // The count stays within the store, an accepted item raises busy, and
   // the final result keeps its last flag.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {{(32-CNT_W){1'b0}}, count_ff} <= VERTEX_DEPTH)
      else $error("vertex count beyond store depth");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (o_valid && o_last) |=> !rsp_valid || rsp_last)
      else $error("final result lost its last flag");

endmodule

// File: design/mts_edge_table.sv
// Open-addressed edge table with linear probing, one probe per cycle.
// Keys, values and an epoch mark share one memory; a clear bumps the epoch.
// Depends on mts_pkg.
module mts_edge_table
   import mts_pkg::*;
#(
   parameter int EDGE_DEPTH = EDGE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               lookup,
   input  logic [KEY_W-1:0]   key,
   input  logic               insert,
   input  logic [IDX_W-1:0]   insert_value,
   output edge_rsp_type       rsp,
   output logic               sweeping
);

   localparam int EW = $clog2(EDGE_DEPTH);
   localparam int CW = EW + 1;

   // Entry memory: key, value and the epoch the entry was written in.
   localparam int ENTRY_W = KEY_W + IDX_W + 8;
   logic [ENTRY_W-1:0] mem [EDGE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [7:0]    epoch_ff, epoch_in;
   logic          wrap_ff, wrap_in;
   logic [EW-1:0] sweep_ff, sweep_in;
   logic          probing_ff, probing_in;
   logic          rdv_ff, rdv_in;
   logic [EW-1:0] slot_ff, slot_in;
   logic [CW-1:0] tries_ff, tries_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [31:0]   prod;
   logic          we;
   logic [EW-1:0] waddr;
   logic [ENTRY_W-1:0] wdata;
   logic          hit_valid, hit_key;
   edge_rsp_type  rsp_in;

   // Only the low bits of the hash product are used, so 32 bits suffice.
   assign prod = {{(32-KEY_W){1'b0}}, key} * HASH_MUL;

   assign sweeping = wrap_ff;

   // Memory read and write, one port each.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[slot_in];
   end

   assign hit_valid = (rd_ff[7:0] == epoch_ff) && !wrap_ff;
   assign hit_key   = rd_ff[ENTRY_W-1 -: KEY_W] == key_ff;

   // Probe sequencing; a clear bumps the epoch, its wrap needs a sweep.
   always_comb begin
      epoch_in = epoch_ff; wrap_in = wrap_ff; sweep_in = sweep_ff;
      probing_in = probing_ff; rdv_in = 1'b0; slot_in = slot_ff;
      tries_in = tries_ff; key_in = key_ff;
      we = 1'b0; waddr = slot_ff; wdata = {key_ff, insert_value, epoch_ff};
      rsp_in = '0;
      if (wrap_ff) begin
         we = 1'b1; waddr = sweep_ff; wdata = {ENTRY_W{1'b0}};
         wdata[7:0] = 8'hFF;
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == EW'(EDGE_DEPTH - 1)) wrap_in = 1'b0;
      end else if (clear) begin
         epoch_in = epoch_ff + 1'b1;
         if (epoch_ff == 8'hFE) begin
            epoch_in = 8'd0; wrap_in = 1'b1; sweep_in = '0;
         end
      end else if (insert) begin
         we = 1'b1;
      end else if (lookup) begin
         key_in = key; slot_in = prod[EW-1:0]; tries_in = '0;
         probing_in = 1'b1; rdv_in = 1'b1;
      end else if (probing_ff && rdv_ff) begin
         if (!hit_valid) begin
            rsp_in.done = 1'b1; probing_in = 1'b0;
         end else if (hit_key) begin
            rsp_in.done = 1'b1; rsp_in.found = 1'b1;
            rsp_in.value = rd_ff[8 +: IDX_W]; probing_in = 1'b0;
         end else if (tries_ff == CW'(EDGE_DEPTH - 1)) begin
            rsp_in.done = 1'b1; rsp_in.fail = 1'b1; probing_in = 1'b0;
         end else begin
            slot_in = slot_ff + 1'b1; tries_in = tries_ff + 1'b1; rdv_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 8'd0; wrap_ff <= 1'b1; sweep_ff <= '0;
         probing_ff <= 1'b0; rdv_ff <= 1'b0; rsp <= '0;
      end else begin
         epoch_ff <= epoch_in; wrap_ff <= wrap_in; sweep_ff <= sweep_in;
         probing_ff <= probing_in; rdv_ff <= rdv_in; rsp <= rsp_in;
      end
      slot_ff <= slot_in; tries_ff <= tries_in; key_ff <= key_in;
   end

endmodule
